// ===== rtl/differential_render_composite_defines.svh =====
// ----------------------------------------------------------------------------
// differential_render_composite_defines
// Assertion macros used by the checker file drc_checker.
// ----------------------------------------------------------------------------
`ifndef DIFFERENTIAL_RENDER_COMPOSITE_DEFINES_SVH
`define DIFFERENTIAL_RENDER_COMPOSITE_DEFINES_SVH
// implication check, clocked on rising edge, disabled in reset
`define DRC_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// next-cycle implication check
`define DRC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

// ===== rtl/drc_pkg.sv =====
// ----------------------------------------------------------------------------
// drc_pkg
// Types and constants of the differential render compositor.
// ----------------------------------------------------------------------------
package drc_pkg;
    localparam int FRAC_BITS  = 12;
    localparam int PIXEL_BITS = 16;
    localparam int W_BITS     = FRAC_BITS + 1;
    localparam logic [PIXEL_BITS-1:0] PIX_MAX = '1;
    localparam logic [W_BITS-1:0]     ONE_FX  = W_BITS'(1) << FRAC_BITS;

    localparam logic [0:0] REG_MASK_SAMPLES = 1'b0;
    localparam logic [0:0] REG_RATIO_BIAS   = 1'b1;

    // configuration data width and register reset values
    localparam int          CFG_BITS      = 12;
    localparam logic [7:0]  SAMPLES_RESET = 8'd16;
    localparam logic [11:0] BIAS_RESET    = 12'd41;

    localparam int NUM_BITS = PIXEL_BITS + 1 + FRAC_BITS;  // dividend width
    localparam int DEN_BITS = PIXEL_BITS + 1;
    localparam int COV_BITS = PIXEL_BITS;

    // weights handed from the front stage to the lanes
    typedef struct packed {
        logic [W_BITS-1:0] geom;
        logic [W_BITS-1:0] loc;
    } weights_t;
endpackage

// ===== rtl/drc_pipe.sv =====
// ----------------------------------------------------------------------------
// drc_pipe
// Generic N-stage restoring divider pipeline: one quotient bit per stage.
// ----------------------------------------------------------------------------
module drc_pipe #(
    parameter int NB = 29,
    parameter int DB = 17,
    parameter int SB = 32
) (
    input  logic          clk,
    input  logic          en,
    input  logic [NB-1:0] num,
    input  logic [DB-1:0] den,
    input  logic [SB-1:0] side,
    output logic [NB-1:0] quo,
    output logic [SB-1:0] side_out
);
    logic [DB:0]   rem_reg  [NB+1];
    logic [NB-1:0] num_reg  [NB+1];
    logic [DB-1:0] den_reg  [NB+1];
    logic [SB-1:0] side_reg [NB+1];

    always_comb
    begin
        rem_reg[0]  = '0;
        num_reg[0]  = num;
        den_reg[0]  = den;
        side_reg[0] = side;
    end

    // one bit per stage, MSB first; num_reg shifts quotient bits in at LSB
    for (genvar s = 0; s < NB; s++) begin : g_st
        logic [DB+1:0] trial;
        logic [DB+1:0] diff;
        assign trial = {rem_reg[s], num_reg[s][NB-1]};
        assign diff  = trial - {2'b00, den_reg[s]};
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[s+1]  <= diff[DB+1] ? trial[DB:0] : diff[DB:0];
                num_reg[s+1]  <= {num_reg[s][NB-2:0], ~diff[DB+1]};
                den_reg[s+1]  <= den_reg[s];
                side_reg[s+1] <= side_reg[s];
            end
        end
    end

    assign quo      = num_reg[NB];
    assign side_out = side_reg[NB];
endmodule

// ===== rtl/drc_lane.sv =====
// ----------------------------------------------------------------------------
// drc_lane
// One colour channel: ratio division, then photo*ratio, mix and blend.
// ----------------------------------------------------------------------------
module drc_lane (
    input  logic                            clk,
    input  logic                            en,
    input  logic [drc_pkg::PIXEL_BITS-1:0] full,
    input  logic [drc_pkg::PIXEL_BITS-1:0] loc,
    input  logic [drc_pkg::PIXEL_BITS-1:0] photo,
    input  logic [11:0]                     bias,
    output logic [drc_pkg::PIXEL_BITS-1:0] ratio,
    output logic [drc_pkg::PIXEL_BITS-1:0] pix_out,
    input  drc_pkg::weights_t               w_in,
    output drc_pkg::weights_t               w_out
);
    localparam int PB = drc_pkg::PIXEL_BITS;
    localparam int FB = drc_pkg::FRAC_BITS;
    localparam int WB = drc_pkg::W_BITS;
    localparam int NB = drc_pkg::NUM_BITS;
    localparam int DB = drc_pkg::DEN_BITS;
    localparam int SB = 2 * PB + 2 * WB;

    logic [NB-1:0] num;
    logic [DB-1:0] den;
    logic [NB-1:0] quo;
    logic [SB-1:0] side_o;
    logic [PB-1:0] full_d, photo_d;
    drc_pkg::weights_t w_d;

    assign num = {(DB'(full) + DB'(bias)), {FB{1'b0}}};
    assign den = DB'(loc) + DB'(bias);

    drc_pipe #(.NB(NB), .DB(DB), .SB(SB)) u_div (
        .clk(clk), .en(en), .num(num), .den(den),
        .side({full, photo, w_in}), .quo(quo), .side_out(side_o)
    );
    assign {full_d, photo_d, w_d} = side_o;

    // stage A: saturate ratio (zero divisor gives all ones already)
    logic [PB-1:0] d_reg, full_a_reg, photo_a_reg;
    drc_pkg::weights_t w_a_reg;
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            d_reg       <= (|quo[NB-1:PB]) ? drc_pkg::PIX_MAX : quo[PB-1:0];
            full_a_reg  <= full_d;
            photo_a_reg <= photo_d;
            w_a_reg     <= w_d;
        end
    end

    // stage B: photo * ratio
    logic [2*PB-1:0] pd_reg;
    logic [PB-1:0] d_b_reg, full_b_reg, photo_b_reg;
    drc_pkg::weights_t w_b_reg;
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pd_reg      <= photo_a_reg * d_reg;
            d_b_reg     <= d_reg;
            full_b_reg  <= full_a_reg;
            photo_b_reg <= photo_a_reg;
            w_b_reg     <= w_a_reg;
        end
    end

    logic [2*PB-FB-1:0] p_sh;
    logic [PB-1:0] p_sat;
    assign p_sh  = pd_reg[2*PB-1:FB];
    assign p_sat = (|p_sh[2*PB-FB-1:PB]) ? drc_pkg::PIX_MAX : p_sh[PB-1:0];

    // stage C: m = (ONE-l)*photo + l*p
    logic [PB+WB-1:0] m_reg, gf_reg;
    logic [PB-1:0] d_c_reg;
    drc_pkg::weights_t w_c_reg;
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            m_reg   <= (PB+WB)'((drc_pkg::ONE_FX - w_b_reg.loc) * photo_b_reg)
                     + (PB+WB)'(w_b_reg.loc * p_sat);
            gf_reg  <= (PB+WB)'(w_b_reg.geom * full_b_reg);
            d_c_reg <= d_b_reg;
            w_c_reg <= w_b_reg;
        end
    end

    // stage D: floor(m*(ONE-g) >> FB) equals the split form of the model
    logic [PB+2*WB-1:0] mc;
    logic [PB+WB+1:0] tot;
    assign mc  = m_reg * (drc_pkg::ONE_FX - w_c_reg.geom);
    assign tot = (PB+WB+2)'(gf_reg) + (PB+WB+2)'(mc[PB+2*WB-1:FB]);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pix_out <= (|tot[PB+WB+1:PB+FB]) ? drc_pkg::PIX_MAX : tot[PB+FB-1:FB];
            ratio   <= d_c_reg;
            w_out   <= w_c_reg;
        end
    end
endmodule

// ===== rtl/differential_render_composite.sv =====
// ----------------------------------------------------------------------------
// differential_render_composite
// Differential render compositor: one pixel beat per clock when the output is
// not stalled; fully pipelined. A beat passes through the 16-stage mask
// weight dividers (pixel data waits alongside them), the 29-stage ratio
// divider in each of the three colour lanes, and then four lane
// stages for ratio saturation, photo product, mix and blend. The whole pipe
// advances when the output register is free or being taken, so a stalled
// output beat holds every stage and in_ready is !out_valid || out_ready.
// Configuration writes act at once; make them only with no pixel in flight.
// ----------------------------------------------------------------------------
module differential_render_composite (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [15:0]                  full_r, full_g, full_b,
    input  logic [15:0]                  local_r, local_g, local_b,
    input  logic [15:0]                  photo_r, photo_g, photo_b,
    input  logic [15:0]                  virt_mask, local_mask,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [15:0]                  out_r, out_g, out_b,
    output logic [15:0]                  ratio_r, ratio_g, ratio_b,
    output logic [12:0]                  geom_weight, local_weight,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic                         cfg_index,
    input  logic [drc_pkg::CFG_BITS-1:0] cfg_data
);
    localparam int PB  = drc_pkg::PIXEL_BITS;
    localparam int WB  = drc_pkg::W_BITS;
    localparam int PDL = drc_pkg::COV_BITS;
    localparam int LAT = PDL + drc_pkg::NUM_BITS + 4;

    logic [7:0]  samples_reg;
    logic [11:0] bias_reg;

    // configuration registers
    assign cfg_ready = 1'b1;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            samples_reg <= drc_pkg::SAMPLES_RESET;
            bias_reg    <= drc_pkg::BIAS_RESET;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                drc_pkg::REG_MASK_SAMPLES: samples_reg <= cfg_data[7:0];
                drc_pkg::REG_RATIO_BIAS:   bias_reg    <= cfg_data[11:0];
                default: ;
            endcase
        end
    end

    // pipeline advance
    logic en;
    logic [LAT-1:0] vld_reg;
    assign en       = !out_valid || out_ready;
    assign in_ready = en;
    assign out_valid = vld_reg[LAT-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[LAT-2:0], in_valid};
    end

    // mask weight dividers: 16-bit quotient, 8-bit divisor, one bit a stage
    logic [7:0] div_s;
    logic [15:0] qg, ql;
    logic gside, lside;
    assign div_s = (samples_reg == 8'd0) ? 8'd1 : samples_reg;

    drc_pipe #(.NB(PDL), .DB(8), .SB(1)) u_wdiv (
        .clk(clk), .en(en), .num(virt_mask), .den(div_s),
        .side(1'b0), .quo(qg), .side_out(gside)
    );
    logic [15:0] ql_q;
    drc_pipe #(.NB(PDL), .DB(8), .SB(1)) u_ldiv (
        .clk(clk), .en(en), .num(local_mask), .den(div_s),
        .side(1'b0), .quo(ql_q), .side_out(lside)
    );
    assign ql = ql_q;

    // clamp weights to one; they enter the lanes with the delayed pixel
    drc_pkg::weights_t w_clamp;
    always_comb
    begin
        w_clamp.geom = (qg > 16'(drc_pkg::ONE_FX)) ? drc_pkg::ONE_FX : qg[WB-1:0];
        w_clamp.loc  = (ql > 16'(drc_pkg::ONE_FX)) ? drc_pkg::ONE_FX : ql[WB-1:0];
    end

    // pixel data waits in a line while the weights are computed
    logic [9*PB-1:0] px_line [PDL+1];
    assign px_line[0] = {full_r, full_g, full_b, local_r, local_g, local_b,
                         photo_r, photo_g, photo_b};
    for (genvar i = 0; i < PDL; i++) begin : g_px
        always_ff @(posedge clk)
            if (en) px_line[i+1] <= px_line[i];
    end
    logic [PB-1:0] fr, fg, fb, lr, lg, lb, pr, pg, pb;
    assign {fr, fg, fb, lr, lg, lb, pr, pg, pb} = px_line[PDL];

    drc_pkg::weights_t wr, wg, wb;
    drc_lane u_r (.clk(clk), .en(en), .full(fr), .loc(lr), .photo(pr), .bias(bias_reg),
        .ratio(ratio_r), .pix_out(out_r), .w_in(w_clamp), .w_out(wr));
    drc_lane u_g (.clk(clk), .en(en), .full(fg), .loc(lg), .photo(pg), .bias(bias_reg),
        .ratio(ratio_g), .pix_out(out_g), .w_in(w_clamp), .w_out(wg));
    drc_lane u_b (.clk(clk), .en(en), .full(fb), .loc(lb), .photo(pb), .bias(bias_reg),
        .ratio(ratio_b), .pix_out(out_b), .w_in(w_clamp), .w_out(wb));

    // merge: weights emerge from the red lane
    assign geom_weight  = wr.geom;
    assign local_weight = wr.loc;

    logic unused;
    assign unused = ^{gside, lside, wg, wb};
endmodule

// ===== rtl/drc_checker.sv =====
// ----------------------------------------------------------------------------
// drc_checker
// Port-level checks of the compositor.
// ----------------------------------------------------------------------------
`include "differential_render_composite_defines.svh"
module drc_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [12:0] geom_weight,
    input logic [12:0] local_weight,
    input logic [15:0] out_r
);
    `DRC_ASSERT_IMP(a_gw_range, clk, rst_n, out_valid, geom_weight <= 13'd4096, "geom weight")
    `DRC_ASSERT_IMP(a_lw_range, clk, rst_n, out_valid, local_weight <= 13'd4096, "local weight")
    `DRC_ASSERT_NEXT(a_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_r),
        "stalled beat changed")
    `DRC_ASSERT_IMP(a_rdy, clk, rst_n, !out_valid, in_ready, "input stalled while free")
endmodule

bind differential_render_composite drc_checker u_chk (.*);
